// File: hdl/smlm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smlm_pkg
// Shared types, codes and constant tables for the line-motion microstep unit.
// ----------------------------------------------------------------------------
package smlm_pkg;

  localparam int unsigned NUM_AXES_MAX = 4;
  localparam int unsigned PHASE_W      = 6;

  localparam logic [19:0] RATE_INC   = 20'd524;
  localparam logic [16:0] AMP_FULL   = 17'd32768;
  localparam logic [9:0]  FRAMES_MAX = 10'd1023;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_SET_DEST = 2'd1,
    ACT_SET_POS  = 2'd2,
    ACT_CANCEL   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_RATE_CRUISE = 2'd0,
    REG_RATE_START  = 2'd1,
    REG_RATE_FINISH = 2'd2,
    REG_HOLD_AMP    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] target_0;
    logic signed [31:0] target_1;
    logic signed [31:0] target_2;
    logic signed [31:0] target_3;
  } in_t;

  typedef struct packed {
    logic               done_res;
    logic [9:0]         hold_frames;
    logic signed [15:0] coil_a_0;
    logic signed [15:0] coil_b_0;
    logic signed [15:0] coil_a_1;
    logic signed [15:0] coil_b_1;
    logic signed [15:0] coil_a_2;
    logic signed [15:0] coil_b_2;
    logic signed [15:0] coil_a_3;
    logic signed [15:0] coil_b_3;
  } out_t;

  // Control word for the serial divider.
  typedef struct packed {
    logic       start;
    logic       top_bit;
    logic [5:0] iters;
  } div_ctl_t;

  // Quarter wave of the sine table, amplitude 30000.
  function automatic logic [14:0] quarter_mag(input logic [4:0] r);
    logic [14:0] v;
    begin
      unique case (r)
        5'd0:  v = 15'd0;
        5'd1:  v = 15'd2941;
        5'd2:  v = 15'd5853;
        5'd3:  v = 15'd8709;
        5'd4:  v = 15'd11481;
        5'd5:  v = 15'd14142;
        5'd6:  v = 15'd16667;
        5'd7:  v = 15'd19032;
        5'd8:  v = 15'd21213;
        5'd9:  v = 15'd23190;
        5'd10: v = 15'd24944;
        5'd11: v = 15'd26458;
        5'd12: v = 15'd27716;
        5'd13: v = 15'd28708;
        5'd14: v = 15'd29424;
        5'd15: v = 15'd29856;
        5'd16: v = 15'd30000;
        default: v = 15'd0;
      endcase
      return v;
    end
  endfunction

  // Magnitude of the sine sample at a 64-step index; the sign is bit 5.
  function automatic logic [14:0] sine_mag(input logic [5:0] n);
    logic [4:0] r;
    begin
      r = n[4] ? (5'd16 - {1'b0, n[3:0]}) : {1'b0, n[3:0]};
      return quarter_mag(r);
    end
  endfunction

endpackage

// File: hdl/stepper_line_motion_microstep_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_line_motion_microstep_unit
// Multi-axis line interpolator with trapezoid rate ramp and sine/cosine
// microstepping; the variable multiplies, the divides and the root run bit-serially.
// ----------------------------------------------------------------------------
// Tick word: a shift-add lag multiply per axis, then an amplitude and a coil
// multiply per axis, then a serial frame divide; a tick at the destination skips them.
// Set destination: a shift-add square per axis, the serial root, then a direction
// divide per axis; set position and cancel finish without leaving idle.
// One word is in work at a time; the output register frees the input side.
// Reset (synchronous, rst_n low) clears all motion state and loads config defaults.
// ----------------------------------------------------------------------------
module stepper_line_motion_microstep_unit #(
  parameter int AXES = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  smlm_pkg::in_t          in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output smlm_pkg::out_t         out_data,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [19:0]            cfg_wdata
);

  localparam int NA = smlm_pkg::NUM_AXES_MAX;

  localparam logic [5:0] SQ_LAST   = 6'd31;
  localparam logic [5:0] TK_LAST   = 6'd39;
  localparam logic [5:0] AMP_LAST  = 6'd16;
  localparam logic [5:0] DIR_ITERS = 6'd17;
  localparam logic [5:0] FR_ITERS  = 6'd41;
  localparam logic [1:0] AXIS_LAST = 2'(AXES - 1);

  typedef enum logic [20:0] {
    ST_IDLE      = 21'h000001,
    ST_SQ_LOAD   = 21'h000002,
    ST_SQ_RUN    = 21'h000004,
    ST_ROOT_GO   = 21'h000008,
    ST_ROOT_WAIT = 21'h000010,
    ST_DV_LOAD   = 21'h000020,
    ST_DV_WAIT   = 21'h000040,
    ST_TK_LOAD   = 21'h000080,
    ST_TK_RUN    = 21'h000100,
    ST_TK_STEP   = 21'h000200,
    ST_RAMP_SUB  = 21'h000400,
    ST_RAMP_MUL  = 21'h000800,
    ST_RAMP_SET  = 21'h001000,
    ST_AMP_LOAD  = 21'h002000,
    ST_AMP_RUN   = 21'h004000,
    ST_COIL_LOAD = 21'h008000,
    ST_COIL_RUN  = 21'h010000,
    ST_COIL_FIN  = 21'h020000,
    ST_FR_GO     = 21'h040000,
    ST_FR_WAIT   = 21'h080000,
    ST_OUT       = 21'h100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration.
  logic [19:0] cruise_r, begin_rate_r, finish_r;
  logic [15:0] hold_r;

  // Motion state.
  logic [31:0]        start_pt_r [NA];
  logic [31:0]        start_pt_nxt [NA];
  logic [31:0]        cur_pt_r [NA];
  logic [31:0]        cur_pt_nxt [NA];
  logic signed [17:0] dir_r [NA];
  logic signed [17:0] dir_nxt [NA];
  logic [5:0]         phase_r [NA];
  logic [5:0]         phase_nxt [NA];
  logic [39:0]        len_r, len_nxt;
  logic [39:0]        ptime_r, ptime_nxt;
  logic [19:0]        rate_r, rate_nxt;
  logic [19:0]        frem_r, frem_nxt;

  // Working registers.
  logic [1:0]         axis_r, axis_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [31:0]        mag_r [NA];
  logic [31:0]        mag_nxt [NA];
  logic               neg_r [NA];
  logic               neg_nxt [NA];
  logic [65:0]        acc_r, acc_nxt;
  logic [65:0]        mcand_r, mcand_nxt;
  logic [39:0]        mplier_r, mplier_nxt;
  logic [31:0]        acc2_r, acc2_nxt;
  logic [31:0]        mcand2_r, mcand2_nxt;
  logic               sgn_a_r, sgn_a_nxt;
  logic               sgn_b_r, sgn_b_nxt;
  logic [48:0]        remain_r, remain_nxt;
  logic [58:0]        rhs_r, rhs_nxt;
  logic               done_flag_r, done_flag_nxt;
  logic [9:0]         frames_r, frames_nxt;
  logic [15:0]        coil_a_r [NA];
  logic [15:0]        coil_a_nxt [NA];
  logic [15:0]        coil_b_r [NA];
  logic [15:0]        coil_b_nxt [NA];

  logic               out_valid_r, out_valid_nxt;
  smlm_pkg::out_t     out_data_r, out_data_nxt;

  // Serial units.
  smlm_pkg::div_ctl_t div_ctl;
  logic [39:0]        div_rem_init;
  logic [39:0]        div_divisor;
  logic [40:0]        div_quot;
  logic               div_done;
  logic               sq_start;
  logic [39:0]        sq_root;
  logic               sq_done;

  logic [31:0]        tgt [NA];
  logic               in_fire;
  logic               out_free;
  logic [65:0]        mul_sum;
  logic [31:0]        mul2_sum;

  assign tgt[0] = in_data.target_0;
  assign tgt[1] = in_data.target_1;
  assign tgt[2] = in_data.target_2;
  assign tgt[3] = in_data.target_3;

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Shared shift-add steps: mul_sum serves every serial multiply, mul2_sum the second coil product.
  assign mul_sum  = acc_r + (mplier_r[0] ? mcand_r : 66'd0);
  assign mul2_sum = acc2_r + (mplier_r[0] ? mcand2_r : 32'd0);

  smlm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .rem_init (div_rem_init),
    .divisor  (div_divisor),
    .quot     (div_quot),
    .done     (div_done)
  );

  smlm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand ({acc_r, 14'd0}),
    .root     (sq_root),
    .done     (sq_done)
  );

  always_comb begin
    div_ctl      = '0;
    div_rem_init = '0;
    div_divisor  = len_r;
    if (state_r == ST_DV_LOAD) begin
      div_ctl.start = 1'b1;
      div_ctl.iters = DIR_ITERS;
      div_rem_init  = 40'({mag_r[axis_r], 6'd0});
    end else if (state_r == ST_FR_GO && rate_r != 20'd0) begin
      div_ctl.start   = 1'b1;
      div_ctl.top_bit = 1'b1;
      div_ctl.iters   = FR_ITERS;
      div_divisor     = {20'd0, rate_r};
    end
  end

  assign sq_start = (state_r == ST_ROOT_GO);

  always_comb begin
    logic [32:0] dif;
    logic [32:0] dif_abs;
    logic [31:0] steps;
    logic [58:0] r_ext;
    logic [58:0] lhs;
    logic [23:0] rate10;
    logic [17:0] dmag;
    logic [20:0] amp_raw;
    logic [16:0] amp;
    logic [5:0]  cos_idx;
    logic [16:0] q17;
    logic [41:0] total;
    logic [15:0] mag_a;
    logic [15:0] mag_b;

    state_nxt     = state_r;
    start_pt_nxt  = start_pt_r;
    cur_pt_nxt    = cur_pt_r;
    dir_nxt       = dir_r;
    phase_nxt     = phase_r;
    len_nxt       = len_r;
    ptime_nxt     = ptime_r;
    rate_nxt      = rate_r;
    frem_nxt      = frem_r;
    axis_nxt      = axis_r;
    cnt_nxt       = cnt_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    acc2_nxt      = acc2_r;
    mcand2_nxt    = mcand2_r;
    sgn_a_nxt     = sgn_a_r;
    sgn_b_nxt     = sgn_b_r;
    remain_nxt    = remain_r;
    rhs_nxt       = rhs_r;
    done_flag_nxt = done_flag_r;
    frames_nxt    = frames_r;
    coil_a_nxt    = coil_a_r;
    coil_b_nxt    = coil_b_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    dif     = '0;
    dif_abs = '0;
    steps   = '0;
    r_ext   = '0;
    lhs     = '0;
    rate10  = '0;
    dmag    = '0;
    amp_raw = '0;
    amp     = '0;
    cos_idx = '0;
    q17     = '0;
    total   = '0;
    mag_a   = '0;
    mag_b   = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data.action)
            smlm_pkg::ACT_SET_DEST: begin
              for (int i = 0; i < AXES; i++) begin
                start_pt_nxt[i] = cur_pt_r[i];
                dif     = {tgt[i][31], tgt[i]} - {cur_pt_r[i][31], cur_pt_r[i]};
                dif_abs = dif[32] ? (33'd0 - dif) : dif;
                mag_nxt[i] = dif_abs[31:0];
                neg_nxt[i] = dif[32];
              end
              acc_nxt   = '0;
              axis_nxt  = '0;
              ptime_nxt = '0;
              rate_nxt  = begin_rate_r;
              state_nxt = ST_SQ_LOAD;
            end
            smlm_pkg::ACT_SET_POS: begin
              for (int i = 0; i < AXES; i++) begin
                cur_pt_nxt[i] = tgt[i];
              end
            end
            smlm_pkg::ACT_CANCEL: begin
              ptime_nxt = 40'(({1'b0, len_r} + 41'd127) >> 7);
            end
            smlm_pkg::ACT_TICK: begin
              for (int i = 0; i < NA; i++) begin
                coil_a_nxt[i] = '0;
                coil_b_nxt[i] = '0;
              end
              frames_nxt = '0;
              axis_nxt   = '0;
              if ({ptime_r, 7'd0} >= {7'd0, len_r}) begin
                done_flag_nxt = 1'b1;
                state_nxt     = ST_OUT;
              end else begin
                done_flag_nxt = 1'b0;
                ptime_nxt     = ptime_r + 40'd1;
                state_nxt     = ST_TK_LOAD;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SQ_LOAD: begin
        mcand_nxt  = {34'd0, mag_r[axis_r]};
        mplier_nxt = {8'd0, mag_r[axis_r]};
        cnt_nxt    = '0;
        state_nxt  = ST_SQ_RUN;
      end

      ST_SQ_RUN: begin
        acc_nxt    = mul_sum;
        mcand_nxt  = {mcand_r[64:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[39:1]};
        cnt_nxt    = cnt_r + 6'd1;
        if (cnt_r == SQ_LAST) begin
          if (axis_r == AXIS_LAST) begin
            state_nxt = ST_ROOT_GO;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = ST_SQ_LOAD;
          end
        end
      end

      ST_ROOT_GO: begin
        state_nxt = ST_ROOT_WAIT;
      end

      ST_ROOT_WAIT: begin
        if (sq_done) begin
          len_nxt  = sq_root;
          axis_nxt = '0;
          if (sq_root == 40'd0) begin
            for (int i = 0; i < AXES; i++) begin
              dir_nxt[i] = '0;
            end
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_DV_LOAD;
          end
        end
      end

      ST_DV_LOAD: begin
        state_nxt = ST_DV_WAIT;
      end

      ST_DV_WAIT: begin
        if (div_done) begin
          q17 = div_quot[16:0];
          dir_nxt[axis_r] = neg_r[axis_r] ? (18'sd0 - $signed({1'b0, q17}))
                                          : $signed({1'b0, q17});
          if (axis_r == AXIS_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = ST_DV_LOAD;
          end
        end
      end

      ST_TK_LOAD: begin
        // Lag in Q.16: (start - current) << 16 plus direction * time.
        dif = {start_pt_r[axis_r][31], start_pt_r[axis_r]}
            - {cur_pt_r[axis_r][31], cur_pt_r[axis_r]};
        acc_nxt    = {{17{dif[32]}}, dif, 16'd0};
        mcand_nxt  = {{48{dir_r[axis_r][17]}}, dir_r[axis_r]};
        mplier_nxt = ptime_r;
        cnt_nxt    = '0;
        state_nxt  = ST_TK_RUN;
      end

      ST_TK_RUN: begin
        acc_nxt    = mul_sum;
        mcand_nxt  = {mcand_r[64:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[39:1]};
        cnt_nxt    = cnt_r + 6'd1;
        if (cnt_r == TK_LAST) begin
          state_nxt = ST_TK_STEP;
        end
      end

      ST_TK_STEP: begin
        // Whole steps, truncated toward zero.
        steps = acc_r[47:16] + {31'd0, acc_r[65] && (acc_r[15:0] != 16'd0)};
        cur_pt_nxt[axis_r] = cur_pt_r[axis_r] + steps;
        phase_nxt[axis_r]  = phase_r[axis_r] + steps[5:0];
        if (axis_r == AXIS_LAST) begin
          state_nxt = ST_RAMP_SUB;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_TK_LOAD;
        end
      end

      ST_RAMP_SUB: begin
        remain_nxt = {9'd0, len_r} - {2'd0, ptime_r, 7'd0};
        state_nxt  = ST_RAMP_MUL;
      end

      ST_RAMP_MUL: begin
        r_ext     = {{10{remain_r[48]}}, remain_r};
        rhs_nxt   = (r_ext << 9) + (r_ext << 3) + (r_ext << 2);
        state_nxt = ST_RAMP_SET;
      end

      ST_RAMP_SET: begin
        lhs = {32'd0, rate_r - finish_r, 7'd0};
        if (rate_r > finish_r && $signed(lhs) >= $signed(rhs_r)) begin
          rate_nxt = (rate_r > smlm_pkg::RATE_INC) ? (rate_r - smlm_pkg::RATE_INC) : 20'd0;
        end else if (({1'b0, rate_r} + {1'b0, smlm_pkg::RATE_INC}) < {1'b0, cruise_r}) begin
          rate_nxt = rate_r + smlm_pkg::RATE_INC;
        end
        axis_nxt  = '0;
        state_nxt = ST_AMP_LOAD;
      end

      ST_AMP_LOAD: begin
        rate10     = {1'b0, rate_r, 3'd0} + {3'd0, rate_r, 1'b0};
        dmag       = dir_r[axis_r][17] ? (18'd0 - dir_r[axis_r]) : dir_r[axis_r];
        acc_nxt    = '0;
        mcand_nxt  = {42'd0, rate10};
        mplier_nxt = {23'd0, dmag[16:0]};
        cnt_nxt    = '0;
        state_nxt  = ST_AMP_RUN;
      end

      ST_AMP_RUN: begin
        acc_nxt    = mul_sum;
        mcand_nxt  = {mcand_r[64:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[39:1]};
        cnt_nxt    = cnt_r + 6'd1;
        if (cnt_r == AMP_LAST) begin
          state_nxt = ST_COIL_LOAD;
        end
      end

      ST_COIL_LOAD: begin
        amp_raw = {5'd0, hold_r} + {1'b0, acc_r[40:21]};
        amp     = (amp_raw > {4'd0, smlm_pkg::AMP_FULL}) ? smlm_pkg::AMP_FULL
                                                          : amp_raw[16:0];
        cos_idx    = phase_r[axis_r] + 6'd16;
        acc_nxt    = '0;
        acc2_nxt   = '0;
        mcand_nxt  = {51'd0, smlm_pkg::sine_mag(phase_r[axis_r])};
        mcand2_nxt = {17'd0, smlm_pkg::sine_mag(cos_idx)};
        sgn_a_nxt  = phase_r[axis_r][5];
        sgn_b_nxt  = cos_idx[5];
        mplier_nxt = {23'd0, amp};
        cnt_nxt    = '0;
        state_nxt  = ST_COIL_RUN;
      end

      ST_COIL_RUN: begin
        acc_nxt    = mul_sum;
        acc2_nxt   = mul2_sum;
        mcand_nxt  = {mcand_r[64:0], 1'b0};
        mcand2_nxt = {mcand2_r[30:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[39:1]};
        cnt_nxt    = cnt_r + 6'd1;
        if (cnt_r == AMP_LAST) begin
          state_nxt = ST_COIL_FIN;
        end
      end

      ST_COIL_FIN: begin
        mag_a = acc_r[30:15];
        mag_b = acc2_r[30:15];
        coil_a_nxt[axis_r] = sgn_a_r ? (16'd0 - mag_a) : mag_a;
        coil_b_nxt[axis_r] = sgn_b_r ? (16'd0 - mag_b) : mag_b;
        if (axis_r == AXIS_LAST) begin
          state_nxt = ST_FR_GO;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_AMP_LOAD;
        end
      end

      ST_FR_GO: begin
        if (rate_r == 20'd0) begin
          frames_nxt = smlm_pkg::FRAMES_MAX;
          state_nxt  = ST_OUT;
        end else begin
          state_nxt = ST_FR_WAIT;
        end
      end

      ST_FR_WAIT: begin
        if (div_done) begin
          total      = {1'b0, div_quot} + {22'd0, frem_r};
          frem_nxt   = total[19:0];
          frames_nxt = (total[41:30] != 12'd0) ? smlm_pkg::FRAMES_MAX : total[29:20];
          state_nxt  = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.done_res    = done_flag_r;
          out_data_nxt.hold_frames = frames_r;
          out_data_nxt.coil_a_0    = coil_a_r[0];
          out_data_nxt.coil_b_0    = coil_b_r[0];
          out_data_nxt.coil_a_1    = coil_a_r[1];
          out_data_nxt.coil_b_1    = coil_b_r[1];
          out_data_nxt.coil_a_2    = coil_a_r[2];
          out_data_nxt.coil_b_2    = coil_b_r[2];
          out_data_nxt.coil_a_3    = coil_a_r[3];
          out_data_nxt.coil_b_3    = coil_b_r[3];
          state_nxt                = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      len_r       <= '0;
      ptime_r     <= '0;
      rate_r      <= '0;
      frem_r      <= '0;
      axis_r      <= '0;
      cnt_r       <= '0;
      for (int i = 0; i < NA; i++) begin
        start_pt_r[i] <= '0;
        cur_pt_r[i]   <= '0;
        dir_r[i]      <= '0;
        phase_r[i]    <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      len_r       <= len_nxt;
      ptime_r     <= ptime_nxt;
      rate_r      <= rate_nxt;
      frem_r      <= frem_nxt;
      axis_r      <= axis_nxt;
      cnt_r       <= cnt_nxt;
      start_pt_r  <= start_pt_nxt;
      cur_pt_r    <= cur_pt_nxt;
      dir_r       <= dir_nxt;
      phase_r     <= phase_nxt;
    end
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    acc_r       <= acc_nxt;
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    acc2_r      <= acc2_nxt;
    mcand2_r    <= mcand2_nxt;
    sgn_a_r     <= sgn_a_nxt;
    sgn_b_r     <= sgn_b_nxt;
    remain_r    <= remain_nxt;
    rhs_r       <= rhs_nxt;
    done_flag_r <= done_flag_nxt;
    frames_r    <= frames_nxt;
    coil_a_r    <= coil_a_nxt;
    coil_b_r    <= coil_b_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cruise_r     <= 20'd346030;
      begin_rate_r <= 20'd52429;
      finish_r     <= 20'd52429;
      hold_r       <= 16'd19661;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smlm_pkg::REG_RATE_CRUISE: cruise_r     <= cfg_wdata;
        smlm_pkg::REG_RATE_START:  begin_rate_r <= cfg_wdata;
        smlm_pkg::REG_RATE_FINISH: finish_r     <= cfg_wdata;
        smlm_pkg::REG_HOLD_AMP:    hold_r       <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.done_res) |->
      (out_data.hold_frames == 10'd0 && out_data.coil_a_0 == 16'sd0 &&
       out_data.coil_b_0 == 16'sd0))
    else $error("done word carries a nonzero payload");

  a_root_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> state_r == ST_ROOT_WAIT)
    else $error("root finished outside its wait state");

  a_div_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DV_WAIT || state_r == ST_FR_WAIT))
    else $error("divider finished outside a wait state");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_valid_r && out_stall) |=> state_r == ST_OUT)
    else $error("result left the sequencer while the output was blocked");
`endif

endmodule

// File: hdl/smlm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smlm_div
// Restoring divider, one quotient bit per cycle, 40-bit divisor.
// ----------------------------------------------------------------------------
module smlm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  smlm_pkg::div_ctl_t  ctl,
  input  logic [39:0]         rem_init,
  input  logic [39:0]         divisor,
  output logic [40:0]         quot,
  output logic                done
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        top_r, top_nxt;
  logic [39:0] rem_r, rem_nxt;
  logic [39:0] dvs_r, dvs_nxt;
  logic [40:0] quo_r, quo_nxt;
  logic [40:0] shifted;
  logic        fits;

  // The remainder stays below the divisor, so one shift never overflows 41 bits.
  assign shifted = {rem_r, top_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    top_nxt  = top_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ctl.iters;
      top_nxt  = ctl.top_bit;
      rem_nxt  = rem_init;
      dvs_nxt  = divisor;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? 40'(shifted - {1'b0, dvs_r}) : shifted[39:0];
      quo_nxt = {quo_r[39:0], fits};
      top_nxt = 1'b0;
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    top_r <= top_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign quot = quo_r;
  assign done = done_r;

endmodule

// File: hdl/smlm_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smlm_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module smlm_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [79:0] radicand,
  output logic [39:0] root,
  output logic        done
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [79:0] rad_r, rad_nxt;
  logic [40:0] rem_r, rem_nxt;
  logic [39:0] root_r, root_nxt;
  logic [42:0] pair;
  logic [42:0] trial;
  logic        fits;

  assign pair  = {rem_r, rad_r[79:78]};
  assign trial = {1'b0, root_r, 2'b01};
  assign fits  = pair >= trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd40;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? 41'(pair - trial) : pair[40:0];
      root_nxt = {root_r[38:0], fits};
      rad_nxt  = {rad_r[77:0], 2'b00};
      cnt_nxt  = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root = root_r;
  assign done = done_r;

endmodule
